// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: field widths, status codes,
// payload structs, controller states and controller/datapath links.
// No dependencies; the top level, controller and datapath use it.
package spq_pkg;

  localparam int DATA_BITS  = 32;
  localparam int PRIO_BITS  = 8;
  localparam int COUNT_BITS = 4;
  localparam int DEPTH      = 8;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                 req_type;
    logic [DATA_BITS-1:0] data_in;
    logic [PRIO_BITS-1:0] prio_in;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [DATA_BITS-1:0]  data_out;
    logic [DATA_BITS-1:0]  head_data;
    logic                  head_valid;
    logic [COUNT_BITS-1:0] entry_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CMP,
    S_PLACE,
    S_POP_CHK,
    S_HEAD_LD,
    S_REPLY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the request, set hole to the tail
    logic set_full;
    logic set_empty;
    logic pop;       // remove the head entry
    logic rd_prev;   // read the slot before the next hole
    logic rd_head;   // read the slot at the head
    logic shift;     // move the entry read last into the hole
    logic place;     // write the new entry into the hole
    logic load_head; // take the read data as the head word
    logic finish;    // drive the result for one cycle
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_deq;
    logic occ_zero;
    logic full;
    logic left_zero;
    logic left_one;
    logic prio_ge;
  } stat_t;

endpackage

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_dpath.
//
//   Channel   Ports                 Transfer when
//   request   start, busy, req      start high and busy low at the edge
//   result    rsp_valid, rsp        rsp_valid high (one cycle, no stall)
//
// A reject or an enqueue into an empty queue goes from S_DECIDE to S_REPLY;
// an enqueue into a held queue takes one S_CMP step per entry read back from
// the RAM, and S_PLACE if the walk reaches the head; a dequeue passes
// S_POP_CHK, then S_HEAD_LD for the head reload read unless it empties it.
// busy drops in the cycle the result is shown, so the next request can
// transfer then. Reset empties the queue; the entry RAM is not cleared.
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t req,
  output spq_pkg::rsp_t rsp,
  output logic          rsp_valid
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  spq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  spq_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cmd      (cmd),
    .stat     (stat),
    .rsp      (rsp),
    .rsp_valid(rsp_valid)
  );

`ifndef SYNTHESIS
  // A result only follows a cycle in which the block was busy.
  a_rsp_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $past(busy))
    else $error("result strobe without preceding busy cycle");

  // An accepted request makes the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request transfer did not start work");

  // The head is valid exactly when the queue holds entries.
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.head_valid == (rsp.entry_count != '0)))
    else $error("head_valid disagrees with entry_count");

  // A full reject only occurs at full occupancy.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == spq_pkg::ST_FULL)) |->
      (rsp.entry_count == spq_pkg::COUNT_BITS'(DEPTH)))
    else $error("full status with queue not full");
`endif

endmodule

// ===== rtl/spq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/spq_ctrl.sv =====
// Controller state machine of the sorted priority queue.
// Depends on spq_pkg for the state, command and status types.
module spq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  spq_pkg::stat_t stat,
  output logic           busy,
  output spq_pkg::cmd_t  cmd
);

  spq_pkg::state_t state;
  spq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::S_IDLE: begin
        if (start) state_next = spq_pkg::S_DECIDE;
      end
      spq_pkg::S_DECIDE: begin
        if (stat.is_deq) begin
          state_next = stat.occ_zero ? spq_pkg::S_REPLY : spq_pkg::S_POP_CHK;
        end else if (stat.full || stat.left_zero) begin
          state_next = spq_pkg::S_REPLY;
        end else begin
          state_next = spq_pkg::S_CMP;
        end
      end
      spq_pkg::S_CMP: begin
        if (stat.prio_ge) begin
          state_next = spq_pkg::S_REPLY;
        end else if (stat.left_one) begin
          state_next = spq_pkg::S_PLACE;
        end
      end
      spq_pkg::S_PLACE:   state_next = spq_pkg::S_REPLY;
      spq_pkg::S_POP_CHK: begin
        state_next = stat.occ_zero ? spq_pkg::S_REPLY : spq_pkg::S_HEAD_LD;
      end
      spq_pkg::S_HEAD_LD: state_next = spq_pkg::S_REPLY;
      spq_pkg::S_REPLY:   state_next = spq_pkg::S_IDLE;
      default:            state_next = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != spq_pkg::S_IDLE);
    unique case (state)
      spq_pkg::S_IDLE: begin
        cmd.capture = start;
      end
      spq_pkg::S_DECIDE: begin
        if (stat.is_deq) begin
          cmd.set_empty = stat.occ_zero;
          cmd.pop       = !stat.occ_zero;
        end else if (stat.full) begin
          cmd.set_full = 1'b1;
        end else if (stat.left_zero) begin
          cmd.place = 1'b1;
        end else begin
          cmd.rd_prev = 1'b1;
        end
      end
      spq_pkg::S_CMP: begin
        if (stat.prio_ge) begin
          cmd.place = 1'b1;
        end else begin
          cmd.shift   = 1'b1;
          cmd.rd_prev = !stat.left_one;
        end
      end
      spq_pkg::S_PLACE: begin
        cmd.place = 1'b1;
      end
      spq_pkg::S_POP_CHK: begin
        cmd.rd_head = !stat.occ_zero;
      end
      spq_pkg::S_HEAD_LD: begin
        cmd.load_head = 1'b1;
      end
      spq_pkg::S_REPLY: begin
        cmd.finish = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/spq_dpath.sv =====
// Datapath of the sorted priority queue: entry RAM, head and count
// registers, insertion walk registers and the result register.
// Depends on spq_pkg and spq_ram.
module spq_dpath #(
  parameter int DEPTH = spq_pkg::DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  spq_pkg::req_t  req,
  input  spq_pkg::cmd_t  cmd,
  output spq_pkg::stat_t stat,
  output spq_pkg::rsp_t  rsp,
  output logic           rsp_valid
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = spq_pkg::DATA_BITS + spq_pkg::PRIO_BITS;
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  logic [IW-1:0]                 head_index;
  logic [CW-1:0]                 occupancy;
  logic [IW-1:0]                 hole;
  logic [IW-1:0]                 hole_next;
  logic [CW-1:0]                 left;
  logic                          req_deq;
  logic [spq_pkg::DATA_BITS-1:0] req_word;
  logic [spq_pkg::PRIO_BITS-1:0] req_prio;
  logic [spq_pkg::DATA_BITS-1:0] head_word;
  spq_pkg::status_t              res_status;
  logic [spq_pkg::DATA_BITS-1:0] res_removed;

  logic [CW:0]     tail_sum;
  logic [IW-1:0]   tail_index;
  logic            ram_we;
  logic [IW-1:0]   ram_raddr;
  logic [EW-1:0]   ram_wdata;
  logic [EW-1:0]   ram_rdata;

  function automatic logic [IW-1:0] slot_prev(input logic [IW-1:0] s);
    return (s == '0) ? LAST : s - 1'b1;
  endfunction

  function automatic logic [IW-1:0] slot_next(input logic [IW-1:0] s);
    return (s == LAST) ? '0 : s + 1'b1;
  endfunction

  // The tail is head plus count, wrapped once.
  assign tail_sum   = (CW + 1)'(head_index) + (CW + 1)'(occupancy);
  assign tail_index = (tail_sum >= (CW + 1)'(DEPTH)) ? IW'(tail_sum - (CW + 1)'(DEPTH))
                                                      : IW'(tail_sum);

  assign hole_next = cmd.shift ? slot_prev(hole) : hole;
  assign ram_raddr = cmd.rd_head ? head_index : slot_prev(hole_next);
  assign ram_we    = cmd.shift || cmd.place;
  assign ram_wdata = cmd.place ? {req_prio, req_word} : ram_rdata;

  spq_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(hole),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign stat.is_deq    = (req_deq == spq_pkg::REQ_DEQ);
  assign stat.occ_zero  = (occupancy == '0);
  assign stat.full      = (occupancy == CW'(DEPTH));
  assign stat.left_zero = (left == '0);
  assign stat.left_one  = (left == CW'(1));
  assign stat.prio_ge   = (ram_rdata[EW-1:spq_pkg::DATA_BITS] >= req_prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      occupancy  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      rsp_valid <= cmd.finish;
      if (cmd.pop) begin
        head_index <= slot_next(head_index);
        occupancy  <= occupancy - 1'b1;
      end else if (cmd.place) begin
        occupancy <= occupancy + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_deq     <= req.req_type;
      req_word    <= req.data_in;
      req_prio    <= req.prio_in;
      hole        <= tail_index;
      left        <= occupancy;
      res_status  <= spq_pkg::ST_DONE;
      res_removed <= '0;
    end else begin
      hole <= hole_next;
      if (cmd.shift) left <= left - 1'b1;
      if (cmd.set_full) res_status <= spq_pkg::ST_FULL;
      if (cmd.set_empty) res_status <= spq_pkg::ST_EMPTY;
      if (cmd.pop) res_removed <= head_word;
    end
    // A new entry that lands on the head slot becomes the head word.
    if (cmd.place && (hole == head_index)) begin
      head_word <= req_word;
    end else if (cmd.load_head) begin
      head_word <= ram_rdata[spq_pkg::DATA_BITS-1:0];
    end
    if (cmd.finish) begin
      rsp.status      <= res_status;
      rsp.data_out    <= res_removed;
      rsp.head_data   <= (occupancy != '0) ? head_word : '0;
      rsp.head_valid  <= (occupancy != '0);
      rsp.entry_count <= spq_pkg::COUNT_BITS'(occupancy);
    end
  end

endmodule
